>>> sv/ipdq_pkg.sv
// Shared types and constants for the dotted-quad address checker.
`timescale 1ns / 1ps

package ipdq_pkg;

    // Character codes
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Group limits and dot count of a complete address
    localparam logic [8:0]  GROUP_MAX    = 9'd255;
    localparam logic [8:0]  GROUP_SAT    = 9'd256;
    localparam logic [11:0] DECIMAL_BASE = 12'd10;
    localparam logic [1:0]  DOTS_NEEDED  = 2'd3;

    // Character classes
    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_DOT   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One classified character
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] digit;
        logic       last;
    } t_tok;

endpackage

>>> sv/ipdq_front.sv
// Front end: accepts characters, classifies them and holds one classified item.
`timescale 1ns / 1ps

module ipdq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_ch,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_push,
    output ipdq_pkg::t_tok o_tok
);

    logic           r_valid;
    ipdq_pkg::t_tok r_tok;
    ipdq_pkg::t_tok n_tok;
    logic           accept;

    // Classify the incoming character
    always_comb begin
        n_tok.last  = i_last;
        n_tok.digit = 4'd0;
        if (i_ch >= ipdq_pkg::CHAR_ZERO && i_ch <= ipdq_pkg::CHAR_NINE) begin
            n_tok.kind  = ipdq_pkg::KIND_DIGIT;
            n_tok.digit = 4'(i_ch - ipdq_pkg::CHAR_ZERO);
        end else if (i_ch == ipdq_pkg::CHAR_DOT) begin
            n_tok.kind = ipdq_pkg::KIND_DOT;
        end else begin
            n_tok.kind = ipdq_pkg::KIND_OTHER;
        end
    end

    // Hand the held item to the queue whenever it has room
    assign o_push  = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_tok   = r_tok;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the classified item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok <= n_tok;
        end
    end

endmodule

>>> sv/ipdq_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module ipdq_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ipdq_pkg::t_tok i_tok,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ipdq_pkg::t_tok o_tok
);

    ipdq_pkg::t_tok                r_mem [ipdq_pkg::Q_DEPTH];
    logic [ipdq_pkg::Q_PTR_W-1:0]  r_wptr;
    logic [ipdq_pkg::Q_PTR_W-1:0]  r_rptr;
    logic [ipdq_pkg::Q_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == ipdq_pkg::Q_CNT_W'(ipdq_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/ipdq_back.sv
// Back end: tracks groups and dots, and registers the verdict on the last character.
`timescale 1ns / 1ps

module ipdq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ipdq_pkg::t_tok i_tok,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_valid_res
);

    logic [8:0]  r_group_value;
    logic        r_group_has_digit;
    logic [1:0]  r_dot_count;
    logic        r_failed;
    logic        r_out_valid;
    logic        r_out_res;

    logic [8:0]  n_group_value;
    logic        n_group_has_digit;
    logic [1:0]  n_dot_count;
    logic        n_failed;
    logic [11:0] acc;
    logic        ok;

    // Take an item unless it carries a verdict and the output is still held
    assign o_pop = i_q_valid && (!i_tok.last || !r_out_valid || !i_stall);

    assign acc = {3'b000, r_group_value} * ipdq_pkg::DECIMAL_BASE + {8'h00, i_tok.digit};

    // Next group state for the item at the queue head
    always_comb begin
        n_group_value     = r_group_value;
        n_group_has_digit = r_group_has_digit;
        n_dot_count       = r_dot_count;
        n_failed          = r_failed;
        unique case (i_tok.kind)
            ipdq_pkg::KIND_DIGIT: begin
                if (acc > {3'b000, ipdq_pkg::GROUP_SAT}) begin
                    n_group_value = ipdq_pkg::GROUP_SAT;
                end else begin
                    n_group_value = acc[8:0];
                end
                n_group_has_digit = 1'b1;
            end
            ipdq_pkg::KIND_DOT: begin
                if (!r_group_has_digit || r_group_value > ipdq_pkg::GROUP_MAX) begin
                    n_failed = 1'b1;
                end
                if (r_dot_count == ipdq_pkg::DOTS_NEEDED) begin
                    n_failed = 1'b1;
                end else begin
                    n_dot_count = r_dot_count + 2'd1;
                end
                n_group_value     = '0;
                n_group_has_digit = 1'b0;
            end
            default: begin
                n_failed = 1'b1;
            end
        endcase
    end

    assign ok = !n_failed && n_group_has_digit && (n_group_value <= ipdq_pkg::GROUP_MAX)
                && (n_dot_count == ipdq_pkg::DOTS_NEEDED);

    // Update group state; clear it after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_value     <= '0;
            r_group_has_digit <= 1'b0;
            r_dot_count       <= '0;
            r_failed          <= 1'b0;
        end else if (o_pop) begin
            if (i_tok.last) begin
                r_group_value     <= '0;
                r_group_has_digit <= 1'b0;
                r_dot_count       <= '0;
                r_failed          <= 1'b0;
            end else begin
                r_group_value     <= n_group_value;
                r_group_has_digit <= n_group_has_digit;
                r_dot_count       <= n_dot_count;
                r_failed          <= n_failed;
            end
        end
    end

    // Hold the verdict until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.last) begin
            r_out_res <= ok;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_out_res;

endmodule

>>> sv/ipv4_dotted_quad_checker.sv
// Top level of the dotted-decimal IPv4 address checker.
`timescale 1ns / 1ps

// Takes a string one character per item, with i_last on the final character, and
// gives one item on o_valid_res for each string: 1 if the string is exactly four
// non-empty decimal groups, each worth at most 255, joined by three dots, else 0.
// Leading zeros are accepted. One character is taken every cycle while o_stall
// is low; the verdict passes through the front register, a queue entry and the
// output register before it is offered. A two-entry queue lets the front keep
// taking items while the output is stalled, until a further last character
// waits at the queue head and the queue and front register fill up.

module ipv4_dotted_quad_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_valid_res
);

    ipdq_pkg::t_tok front_tok;
    ipdq_pkg::t_tok q_tok;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;

    ipdq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_ch     (i_ch),
        .i_last   (i_last),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_tok    (front_tok)
    );

    ipdq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    ipdq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_tok       (q_tok),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_valid_res (o_valid_res)
    );

    // Back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Front end never pushes into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    // A consumed last character yields a verdict next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_tok.last) |=> o_valid)
        else $error("verdict missing after last character");

    // A new verdict only follows a consumed last character
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(q_pop && q_tok.last))
        else $error("verdict without last character");

endmodule
